/* rtl/core/hil3_pkg.sv */
// shared types and constants for the 3d hilbert curve encoder
`timescale 1ns / 1ps

package hil3_pkg;

  // number of curve levels, one pipeline stage each
  localparam int unsigned LEVELS = 8;

  localparam int unsigned AXIS_W  = 8;
  localparam int unsigned OCT_W   = 3;
  localparam int unsigned INDEX_W = 24;

  // visiting order of each octant within one level
  localparam logic [OCT_W-1:0] ORDER_OF_OCTANT [2**OCT_W] = '{
    3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd5
  };

  // one point on its way down the levels
  typedef struct packed {
    logic [AXIS_W-1:0]  red;
    logic [AXIS_W-1:0]  green;
    logic [AXIS_W-1:0]  blue;
    logic [AXIS_W-1:0]  live;   // coordinate bits not yet consumed, msb first
    logic [INDEX_W-1:0] index;
  } hil3_item_t;

endpackage

/* rtl/core/hil3_level.sv */
// one curve level: octant lookup, index append and axis rotation, registered
`timescale 1ns / 1ps

module hil3_level (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hil3_pkg::hil3_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output hil3_pkg::hil3_item_t out_item
);

  logic [hil3_pkg::OCT_W-1:0]  oct;
  logic [hil3_pkg::AXIS_W-1:0] red_rot;
  logic [hil3_pkg::AXIS_W-1:0] green_rot;
  logic [hil3_pkg::AXIS_W-1:0] blue_rot;
  hil3_pkg::hil3_item_t        item_next;

  // once all eight coordinate bits are used the octant is zero
  assign oct = {in_item.red[hil3_pkg::AXIS_W-1], in_item.green[hil3_pkg::AXIS_W-1],
                in_item.blue[hil3_pkg::AXIS_W-1]}
               & {hil3_pkg::OCT_W{in_item.live[hil3_pkg::AXIS_W-1]}};

  always_comb begin
    red_rot   = in_item.red;
    green_rot = in_item.green;
    blue_rot  = in_item.blue;
    unique case (oct) inside
      3'd0: begin
        red_rot   = in_item.blue;
        green_rot = in_item.red;
        blue_rot  = in_item.green;
      end
      3'd1: begin
        green_rot = ~in_item.blue;
        blue_rot  = ~in_item.green;
      end
      3'd2, 3'd6: begin
        red_rot   = in_item.green;
        green_rot = in_item.blue;
        blue_rot  = in_item.red;
      end
      3'd3, 3'd7: begin
        red_rot   = in_item.green;
        green_rot = ~in_item.blue;
        blue_rot  = ~in_item.red;
      end
      3'd4, 3'd5: begin
        red_rot   = ~in_item.green;
        green_rot = ~in_item.red;
      end
      default: begin
      end
    endcase
  end

  // shift consumed bit out so the next level always reads the msb
  always_comb begin
    item_next.red   = {red_rot[hil3_pkg::AXIS_W-2:0], 1'b0};
    item_next.green = {green_rot[hil3_pkg::AXIS_W-2:0], 1'b0};
    item_next.blue  = {blue_rot[hil3_pkg::AXIS_W-2:0], 1'b0};
    item_next.live  = {in_item.live[hil3_pkg::AXIS_W-2:0], 1'b0};
    item_next.index = {in_item.index[hil3_pkg::INDEX_W-hil3_pkg::OCT_W-1:0],
                       hil3_pkg::ORDER_OF_OCTANT[oct]};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

/* rtl/core/hilbert_3d_encode_unit.sv */
// 3d hilbert curve encoder top level: one pipeline stage per curve level
`timescale 1ns / 1ps

// channel  direction  content
// s_*      in         point: red, green, blue
// m_*      out        curve_index
//
// one transaction per cycle sustained while m_tready stays high; one
// register stage per curve level
// each stage holds its item until the next stage takes it, so a stall at
// m_tready backs up stage by stage and bubbles are squeezed out
// rst clears every stage valid; data registers are not reset

module hilbert_3d_encode_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // curve_index [23:0]
);

  localparam int unsigned N = hil3_pkg::LEVELS;

  logic                 valid [N+1];
  logic                 ready [N+1];
  hil3_pkg::hil3_item_t item  [N+1];

  assign valid[0]      = s_tvalid;
  assign s_tready      = ready[0];
  assign item[0].red   = s_tdata[7:0];
  assign item[0].green = s_tdata[15:8];
  assign item[0].blue  = s_tdata[23:16];
  assign item[0].live  = '1;
  assign item[0].index = '0;

  for (genvar k = 0; k < N; k++) begin : g_level
    hil3_level u_level (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid[k]),
      .in_ready (ready[k]),
      .in_item  (item[k]),
      .out_valid(valid[k+1]),
      .out_ready(ready[k+1]),
      .out_item (item[k+1])
    );
  end

  assign ready[N] = m_tready;
  assign m_tvalid = valid[N];
  assign m_tdata  = item[N].index;

  // a free output means the whole chain can move
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is free");

  // input stalls only with a full first stage and a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (valid[1] && m_tvalid && !m_tready))
    else $error("input stalled without backpressure");

  // an accepted transaction lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> valid[1])
    else $error("accepted transaction lost at first stage");

  // a result leaves only when taken
  a_leave: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped without handshake");

endmodule

/* bench/tb_top.sv */
// self-checking bench for the 3d hilbert encoder: random point streams, stalls on both sides
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IDLE_LIMIT     = 3000;
  localparam int unsigned SINK_HOLD_LEN  = 80;
  localparam int unsigned MAX_REPORTS    = 10;

  // visiting order of each octant within one level
  localparam logic [2:0] VISIT_RANK [8] = '{
    3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd5
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // red [7:0], green [15:8], blue [23:16]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // curve_index [23:0]

  // hold-off requests from the stimulus process, served in order by the sink process
  int unsigned hold_reqs;
  int unsigned holds_done;
  bit          free_flow;
  int unsigned sink_wait;
  int unsigned idle_cycles;

  hilbert_3d_encode_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  class curve_scoreboard;
    logic [23:0] index_q[$];
    int unsigned errors;

    // walk the levels top down: octant -> order bits, then rotate the axes
    function automatic logic [23:0] curve_index_of(logic [7:0] r_in, logic [7:0] g_in,
                                                   logic [7:0] b_in);
      logic [7:0]  r, g, b, r0, g0, b0;
      logic [2:0]  oct;
      logic [63:0] acc;
      int unsigned sh;
      r = r_in;
      g = g_in;
      b = b_in;
      acc = '0;
      for (int unsigned k = 0; k < hil3_pkg::LEVELS; k++) begin
        oct = 3'd0;
        // levels past the eighth see no coordinate bit
        if (k < 8) begin
          sh = 7 - k;
          oct = {r[sh], g[sh], b[sh]};
        end
        acc |= 64'(VISIT_RANK[oct]) << (3 * (hil3_pkg::LEVELS - 1 - k));
        r0 = r;
        g0 = g;
        b0 = b;
        case (oct)
          3'd0: begin
            r = b0; g = r0; b = g0;
          end
          3'd1: begin
            g = ~b0; b = ~g0;
          end
          3'd2, 3'd6: begin
            r = g0; g = b0; b = r0;
          end
          3'd3, 3'd7: begin
            r = g0; g = ~b0; b = ~r0;
          end
          default: begin
            r = ~g0; g = ~r0;
          end
        endcase
      end
      return acc[23:0];
    endfunction

    function void note_point(logic [23:0] point);
      index_q.push_back(curve_index_of(point[7:0], point[15:8], point[23:16]));
    endfunction

    function void check_index(logic [23:0] got);
      logic [23:0] want;
      if (index_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result curve_index=%06h", $time, got);
        return;
      end
      want = index_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: curve_index mismatch: expected %06h, got %06h", $time, want, got);
      end
    endfunction

    function int unsigned pending();
      return index_q.size();
    endfunction
  endclass

  curve_scoreboard sb = new();

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // biased toward the corners and the middle of the cube now and then
  function automatic logic [7:0] draw_axis();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  // called on a falling edge; returns on the falling edge after the transaction
  task automatic send_point(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    gap = free_flow ? 0 : draw_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {b, g, r};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_point(draw_axis(), draw_axis(), draw_axis());
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // sink side: random backpressure, free flow, or one long hold-off on request
  initial begin
    m_tready   = 1'b0;
    sink_wait  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        m_tready = 1'b0;
        repeat (SINK_HOLD_LEN) @(negedge clk);
        holds_done++;
        m_tready = 1'b1;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
        if (!free_flow) sink_wait = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_point(s_tdata);
      if (m_tvalid && m_tready) sb.check_index(m_tdata);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] pat;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    hold_reqs = 0;
    free_flow = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // cube corners, one per octant, including all-zero and all-ones
    for (int o = 0; o < 8; o++)
      send_point({8{o[2]}}, {8{o[1]}}, {8{o[0]}});
    // top and bottom bit alone on each axis
    for (int a = 0; a < 3; a++) begin
      pat = 8'h80;
      send_point(a == 0 ? pat : 8'h00, a == 1 ? pat : 8'h00, a == 2 ? pat : 8'h00);
      pat = 8'h01;
      send_point(a == 0 ? pat : 8'h00, a == 1 ? pat : 8'h00, a == 2 ? pat : 8'h00);
    end
    send_point(8'haa, 8'h55, 8'haa);
    send_point(8'h55, 8'haa, 8'h55);
    send_point(8'h7f, 8'h7f, 8'h7f);
    send_point(8'h80, 8'h80, 8'h80);
    send_point(8'hff, 8'h00, 8'h7f);

    send_random(400);

    // source pauses until the pipeline is empty
    wait_drained();
    repeat (4) @(negedge clk);

    // long sink hold-off with the source pushing back to back: fills every stage
    free_flow = 1'b1;
    hold_reqs++;
    send_random(220);
    free_flow = 1'b0;

    send_random(410);

    wait_drained();
    repeat (hil3_pkg::LEVELS + 4) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/hil3_pkg.sv
rtl/core/hil3_level.sv
rtl/core/hilbert_3d_encode_unit.sv
bench/tb_top.sv
